### rtl/bsc_pkg.sv
// Shared types and constants of the bigram successor counter.
package bsc_pkg;

  // Width of a text byte and of the reported counts.
  localparam int SYM_BITS     = 8;
  localparam int OUT_CNT_BITS = 16;

  // Function codes carried by in_func.
  localparam logic FUNC_FEED  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } bsc_state_t;

endpackage

### rtl/bigram_successor_counter.sv
// Top level of the bigram successor counter: byte pair statistics held in RAM.
// A query result is registered from the update state, after the RAM reads of the item.
// Items are taken one at a time: a feed's read-modify-write of the pair RAM ends before the next is taken.
// A query stays in the update state while an earlier result is still waiting on out_ready.
// Reset: control clears at once, then a clearing pass zeroes every entry of the pair RAM,
// during which in_ready stays low.
module bigram_successor_counter #(
  parameter int ALPHABET   = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic [bsc_pkg::SYM_BITS-1:0]         in_symbol,
  input  logic                                 in_start_of_text,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bsc_pkg::SYM_BITS-1:0]         out_best_next,
  output logic [bsc_pkg::OUT_CNT_BITS-1:0]     out_best_count,
  output logic [bsc_pkg::OUT_CNT_BITS-1:0]     out_follow_total,
  output logic                                 out_seen
);

  import bsc_pkg::*;

  // Address widths of the per-byte record store and of the pair counter store.
  localparam int SYM_W      = $clog2(ALPHABET);
  localparam int PAIR_DEPTH = ALPHABET * ALPHABET;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

  localparam logic [PAIR_AW-1:0]    ALPHA_L   = PAIR_AW'(ALPHABET);
  localparam logic [PAIR_AW-1:0]    CLR_LAST  = PAIR_AW'(PAIR_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One record per byte: its best successor, that successor's count and the follow count.
  typedef struct packed {
    logic [SYM_BITS-1:0]   best;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] follow;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Saturating increment of a count.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  // A count reported on a 16-bit port saturates when the count is wider.
  function automatic logic [OUT_CNT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] high;
    high = v >> OUT_CNT_BITS;
    if (high != '0) begin
      clip_out = '1;
    end else begin
      clip_out = OUT_CNT_BITS'(v);
    end
  endfunction

  // Sequencer and clearing pass.
  bsc_state_t         state_r, state_nxt;
  logic [PAIR_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Stream history.
  logic [SYM_W-1:0]    prev_r;
  logic                has_prev_r;
  logic [ALPHABET-1:0] seen_r;
  logic [ALPHABET-1:0] rec_vld_r;

  // The item being worked on.
  logic             func_r;
  logic [SYM_W-1:0] sym_r;
  logic             start_r;
  logic             sym_ok_r;
  logic             rec_ok_r;
  logic             seen_q_r;

  // Result register.
  logic                    out_valid_r;
  logic [SYM_BITS-1:0]     best_next_r;
  logic [OUT_CNT_BITS-1:0] best_count_r;
  logic [OUT_CNT_BITS-1:0] follow_total_r;
  logic                    seen_out_r;

  logic             accept;
  logic             in_sym_ok;
  logic [SYM_W-1:0] in_sym_idx;
  logic [SYM_W-1:0] rec_raddr;
  logic             out_slot_free;
  logic             update_done;
  logic             out_load;

  // Pair RAM ports.
  logic               pair_we;
  logic [PAIR_AW-1:0] pair_waddr;
  logic [COUNT_BITS-1:0] pair_wdata;
  logic               pair_re;
  logic [PAIR_AW-1:0] pair_raddr;
  logic [COUNT_BITS-1:0] pair_rdata;

  // Record RAM ports.
  logic             rec_we;
  logic [REC_W-1:0] rec_wdata;
  logic             rec_re;
  logic [REC_W-1:0] rec_rdata;

  // Update arithmetic.
  rec_t                  rec_cur;
  rec_t                  rec_new;
  logic [COUNT_BITS-1:0] pair_new;
  logic                  pair_do;

  // A symbol outside the alphabet is ignored on a feed and answers zeros on a query.
  assign in_sym_ok  = ({1'b0, in_symbol} < (SYM_BITS + 1)'(ALPHABET));
  assign in_sym_idx = in_symbol[SYM_W-1:0];
  assign accept     = in_valid && in_ready;

  // A feed reads the record of the predecessor; a query reads the record of its own byte.
  assign rec_raddr  = (in_func == FUNC_QUERY) ? in_sym_idx : prev_r;
  assign pair_raddr = PAIR_AW'(prev_r) * ALPHA_L + PAIR_AW'(in_sym_idx);
  assign pair_re    = accept && (in_func == FUNC_FEED);
  assign rec_re     = accept;

  assign out_slot_free = !out_valid_r || out_ready;
  assign update_done   = (func_r == FUNC_FEED) || out_slot_free;

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + PAIR_AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (update_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        in_ready = 1'b0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_UPDATE: begin
        out_load = (func_r == FUNC_QUERY) && out_slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A record that was never written reads as all zero.
  assign rec_cur = rec_ok_r ? rec_t'(rec_rdata) : '0;

  // The pair is counted only when the byte has a predecessor within the same text.
  assign pair_do  = (state_r == ST_UPDATE) && (func_r == FUNC_FEED) && sym_ok_r &&
                    has_prev_r && !start_r;
  assign pair_new = sat_inc(pair_rdata);

  // The best successor moves only on a strictly greater count, so ties keep the earlier one.
  always_comb begin
    rec_new        = rec_cur;
    rec_new.follow = sat_inc(rec_cur.follow);
    if (pair_new > rec_cur.cnt) begin
      rec_new.cnt  = pair_new;
      rec_new.best = SYM_BITS'(sym_r);
    end
  end

  // During the clearing pass the pair RAM is swept with zeros, one entry a cycle.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      pair_we    = 1'b1;
      pair_waddr = clr_cnt_r;
      pair_wdata = '0;
    end else begin
      pair_we    = pair_do;
      pair_waddr = PAIR_AW'(prev_r) * ALPHA_L + PAIR_AW'(sym_r);
      pair_wdata = pair_new;
    end
  end

  assign rec_we    = pair_do;
  assign rec_wdata = REC_W'(rec_new);

  bsc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (pair_re),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  bsc_ram #(
    .WIDTH (REC_W),
    .DEPTH (ALPHABET)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (prev_r),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      prev_r      <= '0;
      has_prev_r  <= 1'b0;
      seen_r      <= '0;
      rec_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (pair_do) begin
        rec_vld_r[prev_r] <= 1'b1;
      end
      // Every fed byte within the alphabet is marked and becomes the predecessor.
      if ((state_r == ST_UPDATE) && (func_r == FUNC_FEED) && sym_ok_r) begin
        seen_r[sym_r] <= 1'b1;
        prev_r        <= sym_r;
        has_prev_r    <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The accepted item and the flags looked up alongside its RAM reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      sym_r    <= in_sym_idx;
      start_r  <= in_start_of_text;
      sym_ok_r <= in_sym_ok;
      rec_ok_r <= rec_vld_r[rec_raddr];
      seen_q_r <= seen_r[in_sym_idx];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sym_ok_r) begin
        best_next_r    <= rec_cur.best;
        best_count_r   <= clip_out(rec_cur.cnt);
        follow_total_r <= clip_out(rec_cur.follow);
        seen_out_r     <= seen_q_r;
      end else begin
        best_next_r    <= '0;
        best_count_r   <= '0;
        follow_total_r <= '0;
        seen_out_r     <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_best_next    = best_next_r;
  assign out_best_count   = best_count_r;
  assign out_follow_total = follow_total_r;
  assign out_seen         = seen_out_r;

endmodule

### rtl/bsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while no read is requested.
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### bench/tb_bigram_successor_counter.sv
// Self-checking testbench for the bigram successor counter, driven by directed and random text.
`timescale 1ns / 100ps

module tb_bigram_successor_counter;
  import bsc_pkg::*;

  // The block is built at its default size; the local model follows the same sizes.
  localparam int ALPHABET   = 256;
  localparam int COUNT_BITS = 16;
  localparam bit [COUNT_BITS-1:0] COUNT_TOP = '1;

  // The clearing pass after reset accepts nothing while it sweeps every pair entry, so the
  // watchdog limit sits well above its length.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;

  // Percentages of cycles in which a side holds off.
  localparam int HOLD_HEAVY = 61;
  localparam int HOLD_BOTH  = 33;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_t;

  // One query answer, laid out as the result ports.
  typedef struct packed {
    logic [SYM_BITS-1:0]     best_next;
    logic [OUT_CNT_BITS-1:0] best_count;
    logic [OUT_CNT_BITS-1:0] follow_total;
    logic                    seen;
  } successor_answer_t;

  // Every input is known from time zero.
  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_func          = FUNC_FEED;
  logic [SYM_BITS-1:0]     in_symbol        = '0;
  logic                    in_start_of_text = 1'b0;
  logic                    out_ready        = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic [SYM_BITS-1:0]     out_best_next;
  logic [OUT_CNT_BITS-1:0] out_best_count;
  logic [OUT_CNT_BITS-1:0] out_follow_total;
  logic                    out_seen;

  bigram_successor_counter #(
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_symbol        (in_symbol),
    .in_start_of_text (in_start_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_next    (out_best_next),
    .out_best_count   (out_best_count),
    .out_follow_total (out_follow_total),
    .out_seen         (out_seen)
  );

  // Local copy of the learnt statistics. Two-state arrays start at zero, which matches the
  // cleared stores after reset.
  bit [COUNT_BITS-1:0] pair_tally   [ALPHABET*ALPHABET];
  bit [SYM_BITS-1:0]   best_succ    [ALPHABET];
  bit [COUNT_BITS-1:0] best_tally   [ALPHABET];
  bit [COUNT_BITS-1:0] follow_tally [ALPHABET];
  bit                  seen_flag    [ALPHABET];
  bit [SYM_BITS-1:0]   prev_sym;
  bit                  have_prev;

  // Answers owed by the block, oldest first.
  successor_answer_t pending_answers[$];

  int fail_count     = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct   = HOLD_HEAVY;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct   = 0;
        recv_stall_pct = HOLD_HEAVY;
      end
      default: begin
        send_gap_pct   = HOLD_BOTH;
        recv_stall_pct = HOLD_BOTH;
      end
    endcase
  endtask

  // Applies one accepted item to the local statistics. A query changes nothing and leaves
  // its answer in the queue; a feed counts the pair it closes, if any, and becomes the
  // predecessor of the next byte.
  task automatic learn_or_answer(logic func, logic [SYM_BITS-1:0] sym, logic sot);
    successor_answer_t   ans;
    int                  pair_idx;
    bit [COUNT_BITS-1:0] tally;
    if (func == FUNC_QUERY) begin
      // The start-of-text flag means nothing on a query. A byte beyond the alphabet
      // reads as all zero.
      ans = '0;
      if (int'(sym) < ALPHABET) begin
        // COUNT_BITS equals the output width here, so no clipping is needed.
        ans.best_next    = best_succ[sym];
        ans.best_count   = best_tally[sym];
        ans.follow_total = follow_tally[sym];
        ans.seen         = seen_flag[sym];
      end
      pending_answers.push_back(ans);
    end else if (int'(sym) < ALPHABET) begin
      // No pair for the first byte after reset, nor for a byte that opens a new text.
      if (have_prev && !sot) begin
        pair_idx = int'(prev_sym) * ALPHABET + int'(sym);
        tally    = pair_tally[pair_idx];
        if (tally != COUNT_TOP) tally++;
        pair_tally[pair_idx] = tally;
        if (follow_tally[prev_sym] != COUNT_TOP) follow_tally[prev_sym]++;
        // Strictly greater: on a tie the successor that got there first stays.
        if (tally > best_tally[prev_sym]) begin
          best_tally[prev_sym] = tally;
          best_succ[prev_sym]  = sym;
        end
      end
      seen_flag[sym] = 1'b1;
      prev_sym       = sym;
      have_prev      = 1'b1;
    end
  endtask

  // Offers one item and returns at the edge where it is taken. Valid is left high, so a
  // following item goes out back to back unless a gap is drawn; it is lowered only when
  // the sender actually idles.
  task automatic offer_byte(logic func, logic [SYM_BITS-1:0] sym, logic sot);
    while (int'($urandom_range(99)) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= func;
    in_symbol        <= sym;
    in_start_of_text <= sot;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    learn_or_answer(func, sym, sot);
  endtask

  // Holds the sender off until every owed answer has come back. The extra edge makes sure
  // valid is never lowered and raised within one step.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // The receiver stalls at random according to the current idling mix.
  always @(posedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
  end

  // Each answer taken from the block is compared with the oldest one owed.
  always @(posedge clk) begin
    successor_answer_t want;
    successor_answer_t got;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = {out_best_next, out_best_count, out_follow_total, out_seen};
      if (pending_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected answer: next=%0h count=%0d follow=%0d seen=%0b",
                   got.best_next, got.best_count, got.follow_total, got.seen);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("answer mismatch: expected next=%0h count=%0d follow=%0d seen=%0b, %s",
                     want.best_next, want.best_count, want.follow_total, want.seen,
                     $sformatf("got next=%0h count=%0d follow=%0d seen=%0b",
                               got.best_next, got.best_count, got.follow_total, got.seen));
        end
      end
    end
  end

  // The watchdog ends the run once nothing has moved on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Queries straight after reset: every record is still empty, whatever the byte, and the
  // start-of-text flag is set on one of them to show that queries ignore it.
  task automatic test_untrained_queries();
    set_idling(IDLE_NONE);
    offer_byte(FUNC_QUERY, 8'h00, 1'b0);
    offer_byte(FUNC_QUERY, 8'hFF, 1'b1);
    offer_byte(FUNC_QUERY, 8'h55, 1'b0);
    wait_for_answers();
  endtask

  // A short hand-made text: the first byte after reset closes no pair, a start of text
  // breaks the chain, a tie keeps the earlier successor and a later lead replaces it.
  // Queries follow feeds back to back, so a read right behind an update is exercised too.
  task automatic test_directed_text();
    set_idling(IDLE_NONE);
    offer_byte(FUNC_FEED,  "h", 1'b0);
    offer_byte(FUNC_QUERY, "h", 1'b0);
    offer_byte(FUNC_FEED,  "e", 1'b0);
    offer_byte(FUNC_FEED,  "h", 1'b1);
    offer_byte(FUNC_FEED,  "i", 1'b0);
    offer_byte(FUNC_QUERY, "h", 1'b0);
    offer_byte(FUNC_FEED,  "h", 1'b0);
    offer_byte(FUNC_FEED,  "i", 1'b0);
    offer_byte(FUNC_QUERY, "h", 1'b0);
    offer_byte(FUNC_QUERY, "e", 1'b1);
    // The extreme byte values, as predecessor and as successor.
    offer_byte(FUNC_FEED,  8'h00, 1'b1);
    offer_byte(FUNC_FEED,  8'hFF, 1'b0);
    offer_byte(FUNC_FEED,  8'hFF, 1'b0);
    offer_byte(FUNC_FEED,  8'h00, 1'b0);
    offer_byte(FUNC_QUERY, 8'h00, 1'b0);
    offer_byte(FUNC_QUERY, 8'hFF, 1'b0);
    wait_for_answers();
  endtask

  // Random text over a small pool of bytes, so that pairs repeat, counts climb and the
  // best successor changes hands, with some bytes from the whole range as noise. Queries
  // mostly ask about pool bytes and now and then about bytes that may never have appeared.
  task automatic test_random_text(idling_t mode, int n_items);
    logic [SYM_BITS-1:0] pool [4];
    logic [SYM_BITS-1:0] sym;
    logic                sot;
    set_idling(mode);
    foreach (pool[i]) pool[i] = SYM_BITS'($urandom_range(255));
    repeat (n_items) begin
      if ($urandom_range(99) < 62) begin
        sym = ($urandom_range(9) == 0) ? SYM_BITS'($urandom_range(255))
                                       : pool[2'($urandom_range(3))];
        sot = ($urandom_range(15) == 0);
        offer_byte(FUNC_FEED, sym, sot);
      end else begin
        sym = ($urandom_range(5) == 0) ? SYM_BITS'($urandom_range(255))
                                       : pool[2'($urandom_range(3))];
        sot = 1'($urandom_range(1));
        offer_byte(FUNC_QUERY, sym, sot);
      end
    end
    wait_for_answers();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // The first item waits out the clearing pass through the handshake.
    test_untrained_queries();
    test_directed_text();
    test_random_text(IDLE_NONE,     110);
    test_random_text(IDLE_SENDER,   110);
    test_random_text(IDLE_RECEIVER, 110);
    test_random_text(IDLE_BOTH,     110);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
